>>> rtl/core/hsc_pkg.sv
// Shared types, constants and bit-map functions for the Hamming SECDED codec.
// Used by every module of the codec; depends on nothing.
package hsc_pkg;

  localparam int unsigned MAX_DATA_BITS = 57;
  localparam int unsigned CODE_W        = 64;
  localparam int unsigned SYN_W         = 6;
  localparam int unsigned CNT_W         = 6;

  typedef enum logic {
    REG_DATA_BITS  = 1'b0,
    REG_EXT_PARITY = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_CORRECTED = 3'd1,
    ST_PARITY    = 3'd2,
    ST_DOUBLE    = 3'd3,
    ST_BAD_POS   = 3'd4
  } status_e;

  typedef struct packed {
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] n;
    logic             ext;
  } cfg_t;

  typedef struct packed {
    logic                     kind;
    logic [MAX_DATA_BITS-1:0] data_word;
    logic [CODE_W-1:0]        received_word;
  } hsc_req_t;

  typedef struct packed {
    logic [CODE_W-1:0]        code_word;
    logic [MAX_DATA_BITS-1:0] corrected_data;
    logic [SYN_W-1:0]         syndrome;
    status_e                  status;
  } hsc_rsp_t;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] word;
  } s1_t;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] word;
    logic [SYN_W-1:0]  syn;
    logic              par;
  } s2_t;

  typedef struct packed {
    logic [CODE_W-1:0] word;
    logic [SYN_W-1:0]  syn;
    status_e           status;
  } s3_t;

  function automatic logic [2:0] check_count(input logic [CNT_W-1:0] k);
    logic [2:0] r;
    if (k <= 6'd1)       r = 3'd2;
    else if (k <= 6'd4)  r = 3'd3;
    else if (k <= 6'd11) r = 3'd4;
    else if (k <= 6'd26) r = 3'd5;
    else                 r = 3'd6;
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] low_mask(input logic [CNT_W:0] w);
    logic [CODE_W-1:0] m;
    for (int i = 0; i < CODE_W; i++) begin
      m[i] = (7'(i) < w);
    end
    return m;
  endfunction

  // data bit j goes to the j-th non-power-of-two position
  function automatic logic [CODE_W-1:0] scatter(input logic [MAX_DATA_BITS-1:0] d);
    logic [CODE_W-1:0] w;
    int j;
    w = '0;
    j = 0;
    for (int p = 1; p < CODE_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        w[p-1] = d[j];
        j++;
      end
    end
    return w;
  endfunction

  function automatic logic [MAX_DATA_BITS-1:0] gather(input logic [CODE_W-1:0] w);
    logic [MAX_DATA_BITS-1:0] d;
    int j;
    d = '0;
    j = 0;
    for (int p = 1; p < CODE_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        d[j] = w[p-1];
        j++;
      end
    end
    return d;
  endfunction

  function automatic logic [SYN_W-1:0] syndrome(input logic [CODE_W-1:0] w);
    logic [SYN_W-1:0] s;
    s = '0;
    for (int p = 1; p < CODE_W; p++) begin
      if (w[p-1]) s = s ^ SYN_W'(p);
    end
    return s;
  endfunction

endpackage

>>> rtl/core/hamming_secded_codec.sv
// Hamming SECDED encoder/decoder, 1 to 57 data bits, optional overall parity bit.
// One request per cycle sustained while out_ready_i holds the output open, through the
// four-stage pipeline (scatter/mask, XOR trees, correct, gather).
// Reset (async, active low) empties the pipeline and sets 57 data bits with parity on.
// Depends on hsc_pkg, hsc_front, hsc_syndrome, hsc_correct, hsc_gather.
module hamming_secded_codec (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  hsc_pkg::cfg_reg_e          cfg_idx_i,
  input  logic [hsc_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  hsc_pkg::hsc_req_t          in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hsc_pkg::hsc_rsp_t          out_rsp_o
);

  logic [hsc_pkg::CNT_W-1:0] data_bits_q;
  logic                      ext_q;
  logic [hsc_pkg::CNT_W-1:0] k;
  hsc_pkg::cfg_t             cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q <= hsc_pkg::CNT_W'(hsc_pkg::MAX_DATA_BITS);
      ext_q       <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hsc_pkg::REG_DATA_BITS:  data_bits_q <= cfg_wdata_i;
        hsc_pkg::REG_EXT_PARITY: ext_q       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (data_bits_q == '0) begin
      k = hsc_pkg::CNT_W'(1);
    end else if (data_bits_q > hsc_pkg::CNT_W'(hsc_pkg::MAX_DATA_BITS)) begin
      k = hsc_pkg::CNT_W'(hsc_pkg::MAX_DATA_BITS);
    end else begin
      k = data_bits_q;
    end
    cfg.k   = k;
    cfg.n   = k + hsc_pkg::CNT_W'(hsc_pkg::check_count(k));
    cfg.ext = ext_q;
  end

  logic         v1, r1, v2, r2, v3, r3;
  hsc_pkg::s1_t d1;
  hsc_pkg::s2_t d2;
  hsc_pkg::s3_t d3;

  hsc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (in_req_i),
    .valid_o (v1),
    .ready_i (r1),
    .data_o  (d1)
  );

  hsc_syndrome u_syndrome (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (v1),
    .ready_o (r1),
    .data_i  (d1),
    .valid_o (v2),
    .ready_i (r2),
    .data_o  (d2)
  );

  hsc_correct u_correct (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (v2),
    .ready_o (r2),
    .data_i  (d2),
    .valid_o (v3),
    .ready_i (r3),
    .data_o  (d3)
  );

  hsc_gather u_gather (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (v3),
    .ready_o (r3),
    .data_i  (d3),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (out_rsp_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1 && v2 && v3 && out_valid_o && !out_ready_i))
    else $error("input stalled while pipeline has room");

  a_corrected_has_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == hsc_pkg::ST_CORRECTED)
      |-> (out_rsp_o.syndrome != '0 && out_rsp_o.syndrome <= cfg.n))
    else $error("correction reported with invalid syndrome");

  a_parity_err_zero_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == hsc_pkg::ST_PARITY)
      |-> (out_rsp_o.syndrome == '0 && cfg.ext))
    else $error("parity bit error with nonzero syndrome");

  a_bad_pos_past_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == hsc_pkg::ST_BAD_POS)
      |-> (out_rsp_o.syndrome > cfg.n))
    else $error("bad position flagged for syndrome inside word");

endmodule

>>> rtl/core/hsc_front.sv
// Stage 1: scatters encode data into code positions or masks the received word.
// Depends on hsc_pkg.
module hsc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hsc_pkg::cfg_t    cfg_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  hsc_pkg::hsc_req_t req_i,
  output logic             valid_o,
  input  logic             ready_i,
  output hsc_pkg::s1_t     data_o
);

  logic                             valid_q;
  hsc_pkg::s1_t                     data_d, data_q;
  logic [hsc_pkg::CODE_W-1:0]       kmask, wmask;

  assign kmask = hsc_pkg::low_mask({1'b0, cfg_i.k});
  assign wmask = hsc_pkg::low_mask({1'b0, cfg_i.n} + 7'(cfg_i.ext));

  always_comb begin
    data_d.kind = req_i.kind;
    if (req_i.kind) begin
      data_d.word = req_i.received_word & wmask;
    end else begin
      data_d.word = hsc_pkg::scatter(req_i.data_word & kmask[hsc_pkg::MAX_DATA_BITS-1:0]);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/hsc_syndrome.sv
// Stage 2: syndrome over the Hamming positions and overall parity of the word.
// Depends on hsc_pkg.
module hsc_syndrome (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hsc_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  hsc_pkg::s1_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output hsc_pkg::s2_t  data_o
);

  logic                       valid_q;
  hsc_pkg::s2_t               data_d, data_q;
  logic [hsc_pkg::CODE_W-1:0] nmask;

  assign nmask = hsc_pkg::low_mask({1'b0, cfg_i.n});

  always_comb begin
    data_d.kind = data_i.kind;
    data_d.word = data_i.word;
    data_d.syn  = hsc_pkg::syndrome(data_i.word & nmask);
    data_d.par  = ^data_i.word;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/hsc_correct.sv
// Stage 3: inserts check and parity bits on encode, classifies and corrects on decode.
// Depends on hsc_pkg.
module hsc_correct (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hsc_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  hsc_pkg::s2_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output hsc_pkg::s3_t  data_o
);

  logic                       valid_q;
  hsc_pkg::s3_t               data_d, data_q;
  logic [hsc_pkg::CODE_W-1:0] bit_n, bit_syn, w;

  assign bit_n   = hsc_pkg::CODE_W'(1) << cfg_i.n;
  assign bit_syn = hsc_pkg::CODE_W'(1) << (data_i.syn - 6'd1);

  always_comb begin
    w             = data_i.word;
    data_d.syn    = '0;
    data_d.status = hsc_pkg::ST_NONE;
    if (!data_i.kind) begin
      w[0]  = w[0]  | data_i.syn[0];
      w[1]  = w[1]  | data_i.syn[1];
      w[3]  = w[3]  | data_i.syn[2];
      w[7]  = w[7]  | data_i.syn[3];
      w[15] = w[15] | data_i.syn[4];
      w[31] = w[31] | data_i.syn[5];
      if (cfg_i.ext && (data_i.par ^ (^data_i.syn))) w = w | bit_n;
    end else begin
      data_d.syn = data_i.syn;
      if (cfg_i.ext && data_i.syn == '0) begin
        if (data_i.par) begin
          w             = w ^ bit_n;
          data_d.status = hsc_pkg::ST_PARITY;
        end
      end else if (cfg_i.ext && !data_i.par) begin
        data_d.status = hsc_pkg::ST_DOUBLE;
      end else if (data_i.syn != '0) begin
        if (data_i.syn > cfg_i.n) begin
          data_d.status = hsc_pkg::ST_BAD_POS;
        end else begin
          w             = w ^ bit_syn;
          data_d.status = hsc_pkg::ST_CORRECTED;
        end
      end
    end
    data_d.word = w;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/hsc_gather.sv
// Stage 4: gathers data bits from the final word into the output register.
// Depends on hsc_pkg.
module hsc_gather (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsc_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  hsc_pkg::s3_t      data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output hsc_pkg::hsc_rsp_t rsp_o
);

  logic                       valid_q;
  hsc_pkg::hsc_rsp_t          rsp_d, rsp_q;
  logic [hsc_pkg::CODE_W-1:0] kmask;

  assign kmask = hsc_pkg::low_mask({1'b0, cfg_i.k});

  always_comb begin
    rsp_d.code_word      = data_i.word;
    rsp_d.corrected_data = hsc_pkg::gather(data_i.word)
                           & kmask[hsc_pkg::MAX_DATA_BITS-1:0];
    rsp_d.syndrome       = data_i.syn;
    rsp_d.status         = data_i.status;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule
